// ===== rtl/core/vector_to_azimuth_elevation_assert.svh =====
// assertion macros for the vector to azimuth and elevation block
`ifndef VECTOR_TO_AZIMUTH_ELEVATION_ASSERT_SVH
`define VECTOR_TO_AZIMUTH_ELEVATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VTAE_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define VTAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/vtae_pkg.sv =====
// shared constants and helper functions for the azimuth and elevation block
package vtae_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int LUT_FRAC    = 24;
  localparam int GUARD_BITS  = 16;
  localparam int ACC_W       = 33;
  localparam int DEG_W       = 34;
  // 9 integer bits cover 0..359, 8 integer bits including sign cover -90..90
  localparam int AZ_W        = 9 + ANGLE_FRAC_BITS_DEF;
  localparam int EL_W        = 8 + ANGLE_FRAC_BITS_DEF;
  localparam int OUT_TDATA_W = ((AZ_W + EL_W + 7) / 8) * 8;
  localparam int GAIN_W      = 31;

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;

  localparam logic [DEG_W-1:0] DEG90  = DEG_W'(90)  << LUT_FRAC;
  localparam logic [DEG_W-1:0] DEG180 = DEG_W'(180) << LUT_FRAC;
  localparam logic [DEG_W-1:0] DEG360 = DEG_W'(360) << LUT_FRAC;
  localparam logic signed [ACC_W-1:0] DEG90_ACC = ACC_W'(90) << LUT_FRAC;

  // atan(2^-i) in degrees scaled by 2^24
  function automatic logic [ACC_W-1:0] atan_deg(input int i);
    logic [ACC_W-1:0] v;
    unique case (i)
      0:  v = 33'd754974720;
      1:  v = 33'd445687602;
      2:  v = 33'd235489088;
      3:  v = 33'd119537938;
      4:  v = 33'd60000934;
      5:  v = 33'd30029717;
      6:  v = 33'd15018523;
      7:  v = 33'd7509720;
      8:  v = 33'd3754917;
      9:  v = 33'd1877466;
      10: v = 33'd938734;
      11: v = 33'd469367;
      12: v = 33'd234684;
      13: v = 33'd117342;
      14: v = 33'd58671;
      15: v = 33'd29335;
      16: v = 33'd14668;
      17: v = 33'd7334;
      18: v = 33'd3667;
      19: v = 33'd1833;
      20: v = 33'd917;
      21: v = 33'd458;
      22: v = 33'd229;
      23: v = 33'd115;
      24: v = 33'd57;
      25: v = 33'd29;
      26: v = 33'd14;
      27: v = 33'd7;
      28: v = 33'd4;
      29: v = 33'd2;
      30: v = 33'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a signed angle accumulator to [0, 90] degrees
  function automatic logic [DEG_W-1:0] clamp_deg90(input logic signed [ACC_W-1:0] acc);
    logic [DEG_W-1:0] r;
    if (acc < 0) begin
      r = '0;
    end else if (acc > DEG90_ACC) begin
      r = DEG90;
    end else begin
      r = DEG_W'($unsigned(acc));
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/vtae_cordic_pipe.sv =====
// pipelined vectoring cordic pass, one stage per register, side data carried along
module vtae_cordic_pipe #(
  parameter int W      = 35,
  parameter int STAGES = 16,
  parameter int SIDE_W = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [W-1:0]                      in_x,
  input  logic [W-1:0]                      in_y,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [W-1:0]                      out_x,
  output logic signed [vtae_pkg::ACC_W-1:0] out_acc,
  output logic [SIDE_W-1:0]                 out_side
);
  import vtae_pkg::*;

  logic [STAGES-1:0]        vld_r;
  logic [W-1:0]             x_r    [STAGES];
  logic [W-1:0]             y_r    [STAGES];
  logic                     yn_r   [STAGES];
  logic signed [ACC_W-1:0]  acc_r  [STAGES];
  logic [SIDE_W-1:0]        side_r [STAGES];
  logic [STAGES:0]          rdy;

  assign rdy[STAGES] = out_ready;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ACC_W-1:0] ANG = $signed(atan_deg(i));
    logic [W-1:0]            xp, yp, xs, ys, x_nxt, y_nxt;
    logic                    ynp, vp, yn_nxt;
    logic signed [ACC_W-1:0] accp, acc_nxt;
    logic [SIDE_W-1:0]       sp;

    if (i == 0) begin : g_first
      assign xp   = in_x;
      assign yp   = in_y;
      assign ynp  = 1'b0;
      assign accp = '0;
      assign vp   = in_valid;
      assign sp   = in_side;
    end else begin : g_next
      assign xp   = x_r[i-1];
      assign yp   = y_r[i-1];
      assign ynp  = yn_r[i-1];
      assign accp = acc_r[i-1];
      assign vp   = vld_r[i-1];
      assign sp   = side_r[i-1];
    end

    assign rdy[i] = !vld_r[i] || rdy[i+1];

    always_comb begin
      xs      = xp >> i;
      ys      = yp >> i;
      x_nxt   = xp + ys;
      acc_nxt = ynp ? (accp - ANG) : (accp + ANG);
      if (yp >= xs) begin
        y_nxt  = yp - xs;
        yn_nxt = ynp;
      end else begin
        y_nxt  = xs - yp;
        yn_nxt = !ynp;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vp) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        yn_r[i]   <= yn_nxt;
        acc_r[i]  <= acc_nxt;
        side_r[i] <= sp;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign out_x     = x_r[STAGES-1];
  assign out_acc   = acc_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

// ===== rtl/core/vector_to_azimuth_elevation.sv =====
// top level: 3-d vector to azimuth and elevation, two pipelined cordic passes
// path: stage 0, stage 1, first cordic pass, stage a, stage b, second cordic pass, output register
// throughput: one transaction per cycle while out_tready is high; each stage holds one item and advances when
//   empty or when the stage after it advances, so bubbles close up under output stall
// reset: synchronous active-low rst_n clears all valid bits; data registers are not reset
// no configuration, no state kept between transactions
module vector_to_azimuth_elevation #(
  parameter int COMPONENT_WIDTH = vtae_pkg::COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STAGES   = vtae_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // x_component, y_component, z_component from bit 0 up, zero padded to bytes
  input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // azimuth (17 bits), elevation (16 bits) from bit 0 up, zero padded to bytes
  output logic [vtae_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import vtae_pkg::*;

  // angle fraction bits fix the output field widths, so they come from the package
  localparam int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF;
  localparam int CW = COMPONENT_WIDTH;
  // working width: guard fraction bits plus headroom for cordic gain on both passes
  localparam int W  = CW + GUARD_BITS + 3;
  localparam int RS = LUT_FRAC - ANGLE_FRAC_BITS;
  localparam logic [DEG_W-1:0] HALF    = DEG_W'(1) << (RS - 1);
  localparam logic [DEG_W-1:0] AZ_WRAP = DEG_W'(360) << ANGLE_FRAC_BITS;
  localparam logic [DEG_W-1:0] EL_90   = DEG_W'(90) << ANGLE_FRAC_BITS;
  localparam int SIDE1_W = W + 4;
  localparam int SIDE2_W = AZ_W + 3;

  // ---------------- stage 0: magnitudes and sign flags ----------------
  logic [CW-1:0] x_in, y_in, z_in;
  assign x_in = in_tdata[CW-1:0];
  assign y_in = in_tdata[2*CW-1:CW];
  assign z_in = in_tdata[3*CW-1:2*CW];

  logic          s0_vld_r, s0_rdy;
  logic [CW-1:0] s0_ax_r, s0_ay_r, s0_az_r;
  logic          s0_xpos_r, s0_ypos_r, s0_zpos_r;
  logic [CW-1:0] ax_nxt, ay_nxt, az_nxt;

  // magnitude of the most negative code fits as an unsigned value
  assign ax_nxt = x_in[CW-1] ? (~x_in + CW'(1)) : x_in;
  assign ay_nxt = y_in[CW-1] ? (~y_in + CW'(1)) : y_in;
  assign az_nxt = z_in[CW-1] ? (~z_in + CW'(1)) : z_in;

  logic s1_vld_r, s1_rdy;
  assign s0_rdy    = !s0_vld_r || s1_rdy;
  assign in_tready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_tvalid) begin
      s0_ax_r   <= ax_nxt;
      s0_ay_r   <= ay_nxt;
      s0_az_r   <= az_nxt;
      s0_xpos_r <= !x_in[CW-1] && (x_in != '0);
      s0_ypos_r <= !y_in[CW-1] && (y_in != '0);
      s0_zpos_r <= !z_in[CW-1] && (z_in != '0);
    end
  end

  // ---------------- stage 1: gain-scaled |z| and guarded x, y ----------------
  logic [CW+GAIN_W-1:0] prod;
  assign prod = (CW+GAIN_W)'(s0_az_r) * (CW+GAIN_W)'(GAIN_Q30);

  logic [W-1:0] s1_x_r, s1_y_r, s1_zk_r;
  logic         s1_xpos_r, s1_ypos_r, s1_zpos_r, s1_ax0_r, s1_ay0_r, s1_az0_r;
  logic         p1_in_ready;

  assign s1_rdy = !s1_vld_r || p1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && s0_vld_r) begin
      s1_x_r    <= W'({s0_ax_r, {GUARD_BITS{1'b0}}});
      s1_y_r    <= W'({s0_ay_r, {GUARD_BITS{1'b0}}});
      s1_zk_r   <= W'(prod >> (30 - GUARD_BITS));
      s1_xpos_r <= s0_xpos_r;
      s1_ypos_r <= s0_ypos_r;
      s1_zpos_r <= s0_zpos_r;
      s1_ax0_r  <= (s0_ax_r == '0);
      s1_ay0_r  <= (s0_ay_r == '0);
      s1_az0_r  <= (s0_az_r == '0);
    end
  end

  // ---------------- first pass: plane angle and K * planar magnitude ----------------
  // side bits from the top: zk, xpos, ypos, zpos, az0 ; axis flags ride separately below
  logic               p1_out_valid, sa_rdy;
  logic [W-1:0]       p1_rmag;
  logic signed [ACC_W-1:0] p1_acc;
  logic [SIDE1_W+2-1:0] p1_side;

  vtae_cordic_pipe #(
    .W      (W),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE1_W + 2)
  ) u_pass_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_vld_r),
    .in_ready  (p1_in_ready),
    .in_x      (s1_x_r),
    .in_y      (s1_y_r),
    .in_side   ({s1_zk_r, s1_xpos_r, s1_ypos_r, s1_zpos_r, s1_az0_r, s1_ax0_r, s1_ay0_r}),
    .out_valid (p1_out_valid),
    .out_ready (sa_rdy),
    .out_x     (p1_rmag),
    .out_acc   (p1_acc),
    .out_side  (p1_side)
  );

  logic [W-1:0] p1_zk;
  logic         p1_xpos, p1_ypos, p1_zpos, p1_az0, p1_ax0, p1_ay0;
  assign {p1_zk, p1_xpos, p1_ypos, p1_zpos, p1_az0, p1_ax0, p1_ay0} = p1_side;

  // ---------------- stage a: axis fixes and quadrant mapping ----------------
  logic             sa_vld_r, sb_rdy;
  logic [DEG_W-1:0] sa_azim_r, a_fix, azim_nxt;
  logic [W-1:0]     sa_rmag_r, sa_zk_r;
  logic             sa_zpos_r, sa_az0_r, sa_zaxis_r;

  always_comb begin
    if (p1_ay0) begin
      a_fix = '0;
    end else if (p1_ax0) begin
      a_fix = DEG90;
    end else begin
      a_fix = clamp_deg90(p1_acc);
    end
    priority if (p1_xpos && p1_ypos) begin
      azim_nxt = a_fix;
    end else if (p1_xpos) begin
      azim_nxt = DEG360 - a_fix;
    end else if (p1_ypos) begin
      azim_nxt = DEG180 - a_fix;
    end else begin
      azim_nxt = DEG180 + a_fix;
    end
  end

  assign sa_rdy = !sa_vld_r || sb_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (sa_rdy) begin
      sa_vld_r <= p1_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_rdy && p1_out_valid) begin
      sa_azim_r  <= azim_nxt;
      sa_rmag_r  <= p1_rmag;
      sa_zk_r    <= p1_zk;
      sa_zpos_r  <= p1_zpos;
      sa_az0_r   <= p1_az0;
      sa_zaxis_r <= p1_ax0 && p1_ay0;
    end
  end

  // ---------------- stage b: round azimuth, wrap 360 to 0 ----------------
  logic             sb_vld_r, p2_in_ready;
  logic [DEG_W-1:0] az_rnd, az_wrapped;
  logic [AZ_W-1:0]  sb_az_r;
  logic [W-1:0]     sb_rmag_r, sb_zk_r;
  logic             sb_zpos_r, sb_az0_r, sb_zaxis_r;

  assign az_rnd     = (sa_azim_r + HALF) >> RS;
  assign az_wrapped = (az_rnd >= AZ_WRAP) ? (az_rnd - AZ_WRAP) : az_rnd;
  assign sb_rdy     = !sb_vld_r || p2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else if (sb_rdy) begin
      sb_vld_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_rdy && sa_vld_r) begin
      // z axis: azimuth forced to zero
      sb_az_r    <= sa_zaxis_r ? '0 : az_wrapped[AZ_W-1:0];
      sb_rmag_r  <= sa_rmag_r;
      sb_zk_r    <= sa_zk_r;
      sb_zpos_r  <= sa_zpos_r;
      sb_az0_r   <= sa_az0_r;
      sb_zaxis_r <= sa_zaxis_r;
    end
  end

  // ---------------- second pass: elevation from (K*r, K*|z|) ----------------
  logic                    p2_out_valid, fin_rdy;
  logic [W-1:0]            p2_x;
  logic signed [ACC_W-1:0] p2_acc;
  logic [SIDE2_W-1:0]      p2_side;

  vtae_cordic_pipe #(
    .W      (W),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE2_W)
  ) u_pass_elev (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sb_vld_r),
    .in_ready  (p2_in_ready),
    .in_x      (sb_rmag_r),
    .in_y      (sb_zk_r),
    .in_side   ({sb_az_r, sb_zpos_r, sb_az0_r, sb_zaxis_r}),
    .out_valid (p2_out_valid),
    .out_ready (fin_rdy),
    .out_x     (p2_x),
    .out_acc   (p2_acc),
    .out_side  (p2_side)
  );

  logic [AZ_W-1:0] p2_az;
  logic            p2_zpos, p2_az0, p2_zaxis;
  assign {p2_az, p2_zpos, p2_az0, p2_zaxis} = p2_side;

  // final magnitude of the second pass is not needed
  logic p2_x_unused;
  assign p2_x_unused = ^p2_x;

  // ---------------- output register: round, sign and special cases ----------------
  logic [DEG_W-1:0] el_rnd, emag;
  logic [EL_W-1:0]  el_nxt;
  logic             fin_vld_r, fin_zaxis_r, fin_az0_r;
  logic [AZ_W-1:0]  fin_az_r;
  logic [EL_W-1:0]  fin_el_r;

  always_comb begin
    el_rnd = (clamp_deg90(p2_acc) + HALF) >> RS;
    priority if (p2_zaxis) begin
      emag = EL_90;
    end else if (p2_az0) begin
      emag = '0;
    end else begin
      emag = el_rnd;
    end
    el_nxt = p2_zpos ? emag[EL_W-1:0] : (~emag[EL_W-1:0] + EL_W'(1));
  end

  assign fin_rdy = !fin_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (fin_rdy) begin
      fin_vld_r <= p2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_rdy && p2_out_valid) begin
      fin_az_r    <= p2_az;
      fin_el_r    <= el_nxt;
      fin_zaxis_r <= p2_zaxis;
      fin_az0_r   <= p2_az0 && !p2_zaxis;
    end
  end

  assign out_tvalid = fin_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-AZ_W-EL_W){1'b0}}, fin_el_r, fin_az_r};

  // ---------------- assertions ----------------
  `include "vector_to_azimuth_elevation_assert.svh"

  `VTAE_ASSERT_HOLDS(a_zaxis_azimuth_zero, out_tvalid && fin_zaxis_r, fin_az_r == '0, "z axis transaction with nonzero azimuth")
  `VTAE_ASSERT_HOLDS(a_flat_elevation_zero, out_tvalid && fin_az0_r, fin_el_r == '0, "z of zero with nonzero elevation")
  `VTAE_ASSERT_NEXT(a_stage0_advance, s0_vld_r && s1_rdy, s1_vld_r, "stage 0 transaction lost on advance")

endmodule
